[hdl/wsi_pkg.sv]
// ----------------------------------------------------------------------------
// wsi_pkg : shared types and constants for the wheel spin integrator
// Field widths, register indexes, reset values and sign helpers.
// ----------------------------------------------------------------------------
package wsi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int CFG_W         = 31;
	localparam int ADDR_W        = 2;
	// quotient bits kept by the dividers; the step saturates at 2^60
	localparam int QUOT_W        = 61;

	localparam logic [CFG_W-1:0] RADIUS_RST  = 31'd19661;
	localparam logic [CFG_W-1:0] INERTIA_RST = 31'd78643;
	localparam logic [CFG_W-1:0] TSTEP_RST   = 31'd546;

	typedef enum logic [ADDR_W-1:0] {
		REG_RADIUS  = 2'd0,
		REG_INERTIA = 2'd1,
		REG_TSTEP   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic neg;
		logic pos;
	} sgn_t;

	// per-item context that travels alongside the step division
	typedef struct packed {
		logic signed [DATA_W-1:0] w;
		sgn_t                     drv_sg;
		sgn_t                     dir;
		logic                     w_small;
		logic                     brake_pos;
		logic                     drv_ok;
		logic                     hold;
		logic                     cfg_zero;
		logic                     net_neg;
		logic                     ovf;
	} ctx_t;

	function automatic sgn_t sgn_of(input logic signed [63:0] x);
		sgn_t s;
		s.neg = x[63];
		s.pos = !x[63] && (x != 64'sd0);
		return s;
	endfunction

	// sign of a product is negative
	function automatic logic mul_neg(input sgn_t a, input sgn_t b);
		return (a.pos && b.neg) || (a.neg && b.pos);
	endfunction

	// sign of a product is positive
	function automatic logic mul_pos(input sgn_t a, input sgn_t b);
		return (a.pos && b.pos) || (a.neg && b.neg);
	endfunction

endpackage

[hdl/wsi_div_pipe.sv]
// ----------------------------------------------------------------------------
// wsi_div_pipe : pipelined restoring divider. One quotient bit per stage,
// Q_W stages. The partial remainder must start below the divisor; the user
// must hold the divisor steady while the pipe holds work; not enforced here.
// ----------------------------------------------------------------------------
module wsi_div_pipe #(
	parameter int DEN_W  = 31,
	parameter int Q_W    = 61,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [DEN_W-1:0]  in_rem,
	input  logic [Q_W-1:0]    in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [Q_W-1:0]    out_quot,
	output logic [SIDE_W-1:0] out_side
);

	logic [Q_W-1:0]    vld_s;
	logic [DEN_W-1:0]  rem_s  [Q_W];
	logic [Q_W-1:0]    num_s  [Q_W];
	logic [Q_W-1:0]    quot_s [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic              cur_vld;
		logic [DEN_W-1:0]  cur_rem;
		logic [Q_W-1:0]    cur_num;
		logic [Q_W-1:0]    cur_quot;
		logic [SIDE_W-1:0] cur_side;
		logic [DEN_W:0]    trial;
		logic [DEN_W:0]    diff;
		logic              take;

		if (k == 0) begin : g_first
			assign cur_vld  = in_vld;
			assign cur_rem  = in_rem;
			assign cur_num  = in_num;
			assign cur_quot = '0;
			assign cur_side = in_side;
		end else begin : g_next
			assign cur_vld  = vld_s[k-1];
			assign cur_rem  = rem_s[k-1];
			assign cur_num  = num_s[k-1];
			assign cur_quot = quot_s[k-1];
			assign cur_side = side_s[k-1];
		end

		always_comb begin
			trial = {cur_rem, cur_num[Q_W-1]};
			diff  = trial - {1'b0, in_den};
			take  = (trial >= {1'b0, in_den});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_s[k]  <= {cur_num[Q_W-2:0], 1'b0};
			quot_s[k] <= {cur_quot[Q_W-2:0], take};
			side_s[k] <= cur_side;
		end
	end

	assign out_vld  = vld_s[Q_W-1];
	assign out_quot = quot_s[Q_W-1];
	assign out_side = side_s[Q_W-1];

endmodule

[hdl/wheel_spin_integrator_top.sv]
// ----------------------------------------------------------------------------
// wheel_spin_integrator_top : one Euler step of a wheel's spin rate
// Net torque, divided by inertia and scaled by the time step, then corrected
// by the brake, rolling-speed and drive rules; signed fixed point throughout.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  --------  -------------------  ---------------------------------------------
//  input     start & !busy        spin_rate road_speed drive_torque
//                                 service_brake parking_brake tire_force
//  result    done (one cycle)     next_spin_rate wheel_locked
//  config    cfg_we               cfg_addr cfg_wdata
//
//  A transaction may enter on every cycle; busy is never raised.
//  The pipe holds two 61-stage bit-per-stage dividers, with five stages
//  ahead of them and six behind.
//  Reset clears the valid bits and loads the register defaults; no sweep.
//  The receiver cannot stall, so the pipe never holds: done simply follows.
// ----------------------------------------------------------------------------
module wheel_spin_integrator_top #(
	parameter int FRAC_BITS = wsi_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              cfg_we,
	input  logic [wsi_pkg::ADDR_W-1:0]        cfg_addr,
	input  logic [wsi_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic signed [wsi_pkg::DATA_W-1:0] spin_rate,
	input  logic signed [wsi_pkg::DATA_W-1:0] road_speed,
	input  logic signed [wsi_pkg::DATA_W-1:0] drive_torque,
	input  logic signed [wsi_pkg::DATA_W-1:0] service_brake,
	input  logic signed [wsi_pkg::DATA_W-1:0] parking_brake,
	input  logic signed [wsi_pkg::DATA_W-1:0] tire_force,
	output logic                              done,
	output logic signed [wsi_pkg::DATA_W-1:0] next_spin_rate,
	output logic                              wheel_locked
);

	localparam int DW  = wsi_pkg::DATA_W;
	localparam int CW  = wsi_pkg::CFG_W;
	localparam int QW  = wsi_pkg::QUOT_W;
	// magnitude width of the net torque
	localparam int NW  = 64 - FRAC_BITS;
	localparam int LOW = NW / 2;
	localparam int HIW = NW - LOW;
	localparam int PW  = NW + CW;
	localparam int LATENCY = QW + 11;
	localparam int SIDE_W  = $bits(wsi_pkg::ctx_t);
	localparam logic signed [DW-1:0] EPS = DW'(((1 << FRAC_BITS) + 5000) / 10000);
	localparam logic [QW-1:0] STEP_LIM = QW'(1) << (QW - 1);

	// configuration registers
	logic [CW-1:0] radius_q, inertia_q, tstep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= wsi_pkg::RADIUS_RST;
			inertia_q <= wsi_pkg::INERTIA_RST;
			tstep_q   <= wsi_pkg::TSTEP_RST;
		end else if (cfg_we) begin
			case (wsi_pkg::reg_idx_t'(cfg_addr))
				wsi_pkg::REG_RADIUS:  radius_q  <= cfg_wdata;
				wsi_pkg::REG_INERTIA: inertia_q <= cfg_wdata;
				wsi_pkg::REG_TSTEP:   tstep_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// ---------------- stage 1: brake sum, hold test, tire force product
	logic                  vld_s1;
	logic signed [DW-1:0]  w_s1, v_s1, drv_s1;
	logic [DW:0]           brake_s1;
	logic signed [63:0]    prod_s1;
	logic                  hold_s1, zero_s1, w_small_s1;
	wsi_pkg::sgn_t         dir_s1;

	logic [DW:0]           brake_c;
	logic                  w_small_c, hold_c;
	wsi_pkg::sgn_t         sg_w_c, sg_v_c;

	always_comb begin
		brake_c = (service_brake[DW-1] ? '0 : {1'b0, service_brake})
			+ (parking_brake[DW-1] ? '0 : {1'b0, parking_brake});
		w_small_c = (spin_rate >= -EPS) && (spin_rate <= EPS);
		hold_c = (brake_c != '0) && w_small_c
			&& (road_speed >= -EPS) && (road_speed <= EPS)
			&& (drive_torque >= -EPS) && (drive_torque <= EPS)
			&& (tire_force >= -EPS) && (tire_force <= EPS);
		sg_w_c = wsi_pkg::sgn_of(64'(spin_rate));
		sg_v_c = wsi_pkg::sgn_of(64'(road_speed));
	end

	// ---------------- stage 2: net torque, brake/drive comparison
	logic                  vld_s2;
	logic signed [NW:0]    net_s2;
	wsi_pkg::ctx_t         ctx_s2;
	logic [QW-1:0]         vnum_s2;
	logic                  vneg_s2;

	logic signed [63:0]    fr_c, brk_c, net_c;
	logic signed [DW+1:0]  drv_x_c, brk_x_c;
	logic [DW-1:0]         vmag_c;
	wsi_pkg::ctx_t         ctx_c;

	always_comb begin
		fr_c    = (prod_s1 + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		brk_c   = $signed({31'b0, brake_s1});
		net_c   = 64'(drv_s1) - fr_c
			- (dir_s1.pos ? brk_c : (dir_s1.neg ? -brk_c : 64'sd0));
		drv_x_c = (DW+2)'(drv_s1);
		brk_x_c = $signed({1'b0, brake_s1});
		vmag_c  = v_s1[DW-1] ? DW'(-v_s1) : DW'(v_s1);

		ctx_c.w         = w_s1;
		ctx_c.drv_sg    = wsi_pkg::sgn_of(64'(drv_s1));
		ctx_c.dir       = dir_s1;
		ctx_c.w_small   = w_small_s1;
		ctx_c.brake_pos = (brake_s1 != '0);
		ctx_c.drv_ok    = dir_s1.pos ? (drv_x_c <= brk_x_c)
			: (dir_s1.neg ? (-drv_x_c <= brk_x_c) : 1'b1);
		ctx_c.hold      = hold_s1;
		ctx_c.cfg_zero  = zero_s1;
		ctx_c.net_neg   = net_c[63];
		ctx_c.ovf       = 1'b0;
	end

	// ---------------- stage 3: |net| times time step, split in two halves
	logic                  vld_s3;
	logic [LOW+CW-1:0]     pp_lo_s3;
	logic [HIW+CW-1:0]     pp_hi_s3;
	wsi_pkg::ctx_t         ctx_s3;
	logic [QW-1:0]         vnum_s3;
	logic                  vneg_s3;

	logic [NW:0]           nmag_c;

	always_comb begin
		nmag_c = net_s2[NW] ? (NW+1)'(-net_s2) : (NW+1)'(net_s2);
	end

	// ---------------- stage 4: join partial products
	logic                  vld_s4;
	logic [PW-1:0]         p_s4;
	wsi_pkg::ctx_t         ctx_s4;
	logic [QW-1:0]         vnum_s4;
	logic                  vneg_s4;

	// ---------------- stage 5: overflow test against inertia
	logic                  vld_s5;
	logic [CW-1:0]         rem0_s5;
	logic [QW-1:0]         num_s5;
	wsi_pkg::ctx_t         ctx_s5;
	logic [QW-1:0]         vnum_s5;
	logic                  vneg_s5;

	logic [CW-1:0]         top_c;
	logic                  ovf_c;
	wsi_pkg::ctx_t         ctx5_c;

	always_comb begin
		top_c      = CW'(p_s4[PW-1:QW]);
		ovf_c      = (top_c >= inertia_q);
		ctx5_c     = ctx_s4;
		ctx5_c.ovf = ovf_c;
	end

	// ---------------- divider pair: step and rolling speed, same latency
	logic                  vld_st, vld_rl;
	logic [QW-1:0]         quot_st, quot_rl;
	logic [SIDE_W-1:0]     side_st;
	logic                  vneg_rl;
	wsi_pkg::ctx_t         ctx_dv;

	wsi_div_pipe #(.DEN_W(CW), .Q_W(QW), .SIDE_W(SIDE_W)) u_div_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s5),
		.in_rem   (rem0_s5),
		.in_num   (num_s5),
		.in_den   (inertia_q),
		.in_side  (ctx_s5),
		.out_vld  (vld_st),
		.out_quot (quot_st),
		.out_side (side_st)
	);

	wsi_div_pipe #(.DEN_W(CW), .Q_W(QW), .SIDE_W(1)) u_div_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s5),
		.in_rem   ('0),
		.in_num   (vnum_s5),
		.in_den   (radius_q),
		.in_side  (vneg_s5),
		.out_vld  (vld_rl),
		.out_quot (quot_rl),
		.out_side (vneg_rl)
	);

	assign ctx_dv = wsi_pkg::ctx_t'(side_st);

	// ---------------- stage 6: signed step, raw next rate, rolling speed
	logic                  vld_s6;
	logic signed [63:0]    next_s6, roll_s6;
	wsi_pkg::ctx_t         ctx_s6;

	logic [QW-1:0]         dmag_c;
	logic signed [63:0]    step_c;

	always_comb begin
		dmag_c = (ctx_dv.ovf || (quot_st > STEP_LIM)) ? STEP_LIM : quot_st;
		step_c = ctx_dv.net_neg ? -$signed(64'(dmag_c)) : $signed(64'(dmag_c));
	end

	// ---------------- stage 7: brakes stop at zero, never reverse
	logic                  vld_s7;
	logic signed [63:0]    next_s7, roll_s7;
	logic                  lock_s7;
	wsi_pkg::sgn_t         sg_wr_s7;
	wsi_pkg::ctx_t         ctx_s7;

	wsi_pkg::sgn_t         sg_w6_c, sg_n6_c;
	logic                  stop_c;

	always_comb begin
		sg_w6_c = wsi_pkg::sgn_of(64'(ctx_s6.w));
		sg_n6_c = wsi_pkg::sgn_of(next_s6);
		stop_c  = ctx_s6.brake_pos && (ctx_s6.dir.pos || ctx_s6.dir.neg) && ctx_s6.drv_ok
			&& (wsi_pkg::mul_neg(sg_w6_c, sg_n6_c)
			|| (ctx_s6.w_small && !wsi_pkg::mul_pos(sg_n6_c, ctx_s6.dir)));
	end

	// ---------------- stage 8: braked rolling clamp, unbraked reverse stop
	logic                  vld_s8;
	logic signed [63:0]    next_s8, roll_s8;
	logic                  lock_s8;
	wsi_pkg::sgn_t         sg_wr_s8;
	wsi_pkg::ctx_t         ctx_s8;

	wsi_pkg::sgn_t         sg_w7_c, sg_n7_c, sg_nr7_c;
	logic                  clamp7_c, zero7_c;

	always_comb begin
		sg_w7_c  = wsi_pkg::sgn_of(64'(ctx_s7.w));
		sg_n7_c  = wsi_pkg::sgn_of(next_s7);
		sg_nr7_c = wsi_pkg::sgn_of(next_s7 - roll_s7);
		clamp7_c = ctx_s7.brake_pos && (ctx_s7.dir.pos || ctx_s7.dir.neg)
			&& !wsi_pkg::mul_pos(sg_wr_s7, ctx_s7.dir)
			&& wsi_pkg::mul_pos(sg_nr7_c, ctx_s7.dir);
		zero7_c  = !ctx_s7.brake_pos && wsi_pkg::mul_neg(ctx_s7.drv_sg, sg_w7_c)
			&& wsi_pkg::mul_neg(sg_w7_c, sg_n7_c);
	end

	// ---------------- stage 9: driven and free-wheel clamps, bound cap
	logic                  vld_s9;
	logic signed [63:0]    next_s9, cap_s9;
	logic                  lock_s9, roll_nn_s9;
	wsi_pkg::ctx_t         ctx_s9;

	wsi_pkg::sgn_t         sg_nr8_c;
	logic                  drv_nz8_c, clamp8_c;
	logic signed [63:0]    w8_c;

	always_comb begin
		sg_nr8_c  = wsi_pkg::sgn_of(next_s8 - roll_s8);
		drv_nz8_c = ctx_s8.drv_sg.pos || ctx_s8.drv_sg.neg;
		w8_c      = 64'(ctx_s8.w);
		if (drv_nz8_c) begin
			clamp8_c = !ctx_s8.brake_pos
				&& !wsi_pkg::mul_neg(sg_wr_s8, ctx_s8.drv_sg)
				&& wsi_pkg::mul_neg(sg_nr8_c, ctx_s8.drv_sg);
		end else begin
			clamp8_c = !ctx_s8.brake_pos && wsi_pkg::mul_neg(sg_wr_s8, sg_nr8_c);
		end
	end

	// ---------------- stage 10: one-sided bound
	logic                  vld_s10;
	logic signed [63:0]    next_s10;
	logic                  lock_s10;
	wsi_pkg::ctx_t         ctx_s10;

	logic                  spin_up_c;
	logic signed [63:0]    bound_c;

	always_comb begin
		spin_up_c = roll_nn_s9 ? ctx_s9.drv_sg.pos : ctx_s9.drv_sg.neg;
		bound_c   = next_s9;
		if (!spin_up_c) begin
			if (roll_nn_s9 && (next_s9 > cap_s9)) begin
				bound_c = cap_s9;
			end else if (!roll_nn_s9 && (next_s9 < cap_s9)) begin
				bound_c = cap_s9;
			end
		end
	end

	// ---------------- output stage: saturate, apply special cases
	logic                  done_q;
	logic signed [DW-1:0]  next_out_q;
	logic                  lock_out_q;
	logic signed [DW-1:0]  sat_c;

	always_comb begin
		if (next_s10 > 64'sd2147483647) begin
			sat_c = {1'b0, {(DW-1){1'b1}}};
		end else if (next_s10 < -64'sd2147483648) begin
			sat_c = {1'b1, {(DW-1){1'b0}}};
		end else begin
			sat_c = next_s10[DW-1:0];
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_st && vld_rl;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			done_q  <= vld_s10;
		end
	end

	// payload: no reset, advance every cycle
	always_ff @(posedge clk) begin
		// stage 1
		w_s1       <= spin_rate;
		v_s1       <= road_speed;
		drv_s1     <= drive_torque;
		brake_s1   <= brake_c;
		prod_s1    <= $signed(tire_force) * $signed({1'b0, radius_q});
		hold_s1    <= hold_c;
		zero_s1    <= (radius_q == '0) || (inertia_q == '0) || (tstep_q == '0);
		w_small_s1 <= w_small_c;
		dir_s1     <= (sg_w_c.pos || sg_w_c.neg) ? sg_w_c : sg_v_c;
		// stage 2
		net_s2     <= net_c[NW:0];
		ctx_s2     <= ctx_c;
		vnum_s2    <= QW'({vmag_c, {FRAC_BITS{1'b0}}});
		vneg_s2    <= v_s1[DW-1];
		// stage 3
		pp_lo_s3   <= nmag_c[LOW-1:0] * tstep_q;
		pp_hi_s3   <= nmag_c[NW-1:LOW] * tstep_q;
		ctx_s3     <= ctx_s2;
		vnum_s3    <= vnum_s2;
		vneg_s3    <= vneg_s2;
		// stage 4
		p_s4       <= (PW'(pp_hi_s3) << LOW) + PW'(pp_lo_s3);
		ctx_s4     <= ctx_s3;
		vnum_s4    <= vnum_s3;
		vneg_s4    <= vneg_s3;
		// stage 5: drop the remainder seed on overflow to keep the divider sane
		rem0_s5    <= ovf_c ? '0 : top_c;
		num_s5     <= p_s4[QW-1:0];
		ctx_s5     <= ctx5_c;
		vnum_s5    <= vnum_s4;
		vneg_s5    <= vneg_s4;
		// stage 6
		next_s6    <= 64'(ctx_dv.w) + step_c;
		roll_s6    <= vneg_rl ? -$signed(64'(quot_rl)) : $signed(64'(quot_rl));
		ctx_s6     <= ctx_dv;
		// stage 7
		next_s7    <= stop_c ? 64'sd0 : next_s6;
		lock_s7    <= stop_c;
		roll_s7    <= roll_s6;
		sg_wr_s7   <= wsi_pkg::sgn_of(64'(ctx_s6.w) - roll_s6);
		ctx_s7     <= ctx_s6;
		// stage 8
		next_s8    <= clamp7_c ? roll_s7 : (zero7_c ? 64'sd0 : next_s7);
		lock_s8    <= lock_s7;
		roll_s8    <= roll_s7;
		sg_wr_s8   <= sg_wr_s7;
		ctx_s8     <= ctx_s7;
		// stage 9
		next_s9    <= clamp8_c ? roll_s8 : next_s8;
		lock_s9    <= lock_s8;
		roll_nn_s9 <= !roll_s8[63];
		cap_s9     <= (!roll_s8[63]) ? ((w8_c > roll_s8) ? w8_c : roll_s8)
			: ((w8_c < roll_s8) ? w8_c : roll_s8);
		ctx_s9     <= ctx_s8;
		// stage 10
		next_s10   <= bound_c;
		lock_s10   <= lock_s9;
		ctx_s10    <= ctx_s9;
		// output: a zero register beats the standstill hold
		if (ctx_s10.cfg_zero) begin
			next_out_q <= '0;
			lock_out_q <= 1'b0;
		end else if (ctx_s10.hold) begin
			next_out_q <= '0;
			lock_out_q <= 1'b1;
		end else begin
			next_out_q <= sat_c;
			lock_out_q <= lock_s10;
		end
	end

	assign done           = done_q;
	assign next_spin_rate = next_out_q;
	assign wheel_locked   = lock_out_q;

	// every accepted transaction comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("result strobe missing after pipeline latency");

	// both dividers advance in lockstep
	a_div_align: assert property (@(posedge clk) disable iff (!arst_n)
		vld_st == vld_rl)
		else $error("step and rolling-speed dividers out of step");

	// a zero register yields a zero, unlocked result
	a_cfg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s10 && ctx_s10.cfg_zero) |=> (done && !wheel_locked && next_spin_rate == '0))
		else $error("zero register did not clear the result");

endmodule
